@@ src/hbcr_pkg.sv @@
package hbcr_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam int MASK_COLS = 64;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  bin_index;
        logic [15:0] bin_count;
        logic [5:0]  row_index;
    } req_word_t;

    typedef struct packed {
        logic [5:0]  row_number;
        logic [6:0]  column_base;
        logic [63:0] black_mask;
        logic        last;
    } rsp_word_t;

    typedef enum logic {
        CMD_LOAD,
        CMD_RENDER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [6:0]  bin_index;
        logic [15:0] bin_count;
        logic [5:0]  row_index;
    } cmd_t;

endpackage

@@ src/hbcr_ram.sv @@
module hbcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/hbcr_front.sv @@
module hbcr_front #(
    parameter int COLS = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  hbcr_pkg::req_word_t req,
    output logic              cmd_valid,
    output hbcr_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    hbcr_pkg::cmd_t entry_reg [2];
    hbcr_pkg::cmd_t entry_next [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           take;
    logic           push;
    logic           do_pop;
    hbcr_pkg::cmd_t new_cmd;

    assign req_stall = (fill_reg == 2'd2);
    assign take      = req_valid && !req_stall;

    // Loads to a bin outside the chart are dropped here and never reach the back end.
    always_comb
    begin
        new_cmd.kind      = (req.opcode == hbcr_pkg::OP_RENDER) ? hbcr_pkg::CMD_RENDER
                                                                : hbcr_pkg::CMD_LOAD;
        new_cmd.bin_index = req.bin_index;
        new_cmd.bin_count = req.bin_count;
        new_cmd.row_index = req.row_index;
    end

    assign push      = take && ((req.opcode == hbcr_pkg::OP_RENDER) ||
                                (32'(req.bin_index) < COLS));
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_pop    = cmd_valid && cmd_pop;

    always_comb
    begin
        entry_next  = entry_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            entry_next[wr_ptr_reg] = new_cmd;
            wr_ptr_next            = !wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/hbcr_back.sv @@
module hbcr_back #(
    parameter int ROWS       = 64,
    parameter int COLS       = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  hbcr_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output hbcr_pkg::rsp_word_t rsp
);

    localparam int DEPTH = (COLS < 128) ? COLS : 128;
    localparam int AW    = $clog2(DEPTH);
    localparam int RB    = $clog2(ROWS + 2);
    localparam int PW    = COUNT_BITS + RB;
    localparam logic [PW-1:0] ROWS_W = PW'(ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_SCAN,
        S_FLUSH,
        S_EMIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [COUNT_BITS-1:0] peak_next;
    logic [5:0]          row_reg;
    logic [5:0]          row_next;
    logic [PW-1:0]       thr_reg;
    logic [PW-1:0]       thr_next;
    logic                white_reg;
    logic                white_next;
    logic [6:0]          col_reg;
    logic [6:0]          col_next;
    logic                rd_v_reg;
    logic                rd_v_next;
    logic [6:0]          rd_col_reg;
    logic [6:0]          rd_col_next;
    logic [63:0]         mask_reg;
    logic [63:0]         mask_next;
    hbcr_pkg::rsp_word_t rsp_reg;
    hbcr_pkg::rsp_word_t rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    logic                  wr_en;
    logic [COUNT_BITS-1:0] load_cnt;
    logic [COUNT_BITS-1:0] rd_data;
    logic [RB-1:0]         factor;
    logic                  black;

    assign load_cnt = COUNT_BITS'(cmd.bin_count);
    assign cmd_pop  = (state_reg == S_IDLE);
    assign wr_en    = cmd_valid && cmd_pop && (cmd.kind == hbcr_pkg::CMD_LOAD);

    hbcr_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cmd.bin_index[AW-1:0]),
        .wr_data (load_cnt),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // A pixel is black when count*ROWS reaches (ROWS+1-row)*peak.
    assign factor = RB'(ROWS + 1) - RB'(row_reg);
    assign black  = rd_v_reg && !white_reg && (32'(rd_col_reg) < DEPTH) &&
                    ((PW'(rd_data) * ROWS_W) >= thr_reg);

    always_comb
    begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        row_next       = row_reg;
        thr_next       = thr_reg;
        white_next     = white_reg;
        col_next       = col_reg;
        rd_v_next      = 1'b0;
        rd_col_next    = rd_col_reg;
        mask_next      = mask_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (black)
        begin
            mask_next[rd_col_reg[5:0]] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == hbcr_pkg::CMD_RENDER)
                    begin
                        row_next   = cmd.row_index;
                        state_next = S_MULT;
                    end
                    else if ((cmd.bin_index == 7'd0) || (load_cnt > peak_reg))
                    begin
                        peak_next = load_cnt;
                    end
                end
            end
            S_MULT:
            begin
                thr_next   = PW'(factor) * PW'(peak_reg);
                white_next = (32'(row_reg) >= ROWS) || (peak_reg == '0);
                col_next   = 7'd0;
                mask_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                rd_v_next   = 1'b1;
                rd_col_next = col_reg;
                col_next    = col_reg + 7'd1;
                if (col_reg[5:0] == 6'd63)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.row_number  = row_reg;
                    rsp_next.column_base = {rd_col_reg[6], 6'd0};
                    rsp_next.black_mask  = mask_reg;
                    rsp_next.last        = rd_col_reg[6];
                    rsp_valid_next       = 1'b1;
                    mask_next            = '0;
                    state_next           = rd_col_reg[6] ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            peak_reg      <= '0;
            row_reg       <= '0;
            thr_reg       <= '0;
            white_reg     <= 1'b1;
            col_reg       <= '0;
            rd_v_reg      <= 1'b0;
            rd_col_reg    <= '0;
            mask_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            row_reg       <= row_next;
            thr_reg       <= thr_next;
            white_reg     <= white_next;
            col_reg       <= col_next;
            rd_v_reg      <= rd_v_next;
            rd_col_reg    <= rd_col_next;
            mask_reg      <= mask_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/histogram_bar_chart_render.sv @@
// Histogram bar-chart renderer.
// The request channel (req_valid, req_stall, req) takes one word per handshake. A load word
// writes one bin count and updates the running peak; loading bin 0 restarts the peak. A
// render word names one image row. Loads to a bin outside the chart are dropped.
// The response channel (rsp_valid, rsp_stall, rsp) gives two words per render: a 64-column
// black mask for columns 0 to 63 and then one for columns 64 to 127, the second with last set.
// Request words go into a two-entry queue, so the front side keeps accepting while the back
// end works or while a response waits on a stalled receiver.
// A load is handled in the back end without leaving its idle state. A render first computes the
// threshold multiply, then for each half reads the bin memory one column a cycle, flushes the
// last read and emits that half's response word.
// While rsp_stall is high the response word holds and the back end waits before its next
// response; the queue then fills and req_stall rises.
// Reset clears the peak, the queue and the response register. Bin contents are undefined
// until loaded.
module histogram_bar_chart_render #(
    parameter int ROWS       = 64,
    parameter int COLS       = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  hbcr_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output hbcr_pkg::rsp_word_t rsp
);

    logic           cmd_valid;
    logic           cmd_pop;
    hbcr_pkg::cmd_t cmd;

    hbcr_front #(
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    hbcr_back #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
